// ===== rtl/wnnc_pkg.sv =====
// Shared types and codes for the weighted nearest-neighbour classifier core.
// No dependencies; imported by the top level and wnnc_dist.
`default_nettype none
package wnnc_pkg;

   typedef enum logic [2:0] {
      MODE_WEIGHT = 3'd0,
      MODE_TRAIN  = 3'd1,
      MODE_QUERY  = 3'd2,
      MODE_LOO    = 3'd3,
      MODE_CLEAR  = 3'd4
   } wnnc_mode_type;

   typedef enum logic [1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_FEATURES  = 2'd1,
      CSR_SAMPLES   = 2'd2
   } wnnc_csr_type;

   localparam int unsigned COUNT_BITS = 20;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = 20'hFFFFF;

   // per-feature tag that travels alongside the distance pipeline
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
      logic used;
   } wnnc_tag_type;

endpackage
`default_nettype wire

// ===== rtl/weighted_nearest_neighbour_classifier_core.sv =====
// Top level: control sequencer, sample memories and nearest-sample search.
// Depends on wnnc_pkg, wnnc_ram and wnnc_dist.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tuser mode, tdata, tlast = last
//  rsp     | out | rsp_tvalid/tready    | tdata result
//  csr     | in  | csr_valid/ready      | csr_index, csr_data
//
// Store items are written as they are accepted. A classification scans n samples of
// kf features each, kf = feature_count limited to 1..64, n the effective train
// count (less one for leave-one-out of a sample below it): one feature read per cycle.
// Reset clears control and counters and resets configuration; memories are not cleared.
// Requests are held off while a classification runs; a result still waiting
// holds the next classification at its end.
`default_nettype none
module weighted_nearest_neighbour_classifier_core
   import wnnc_pkg::*;
#(
   parameter int unsigned MAX_TRAIN    = 1024,
   parameter int unsigned MAX_FEATURES = 64,
   parameter int unsigned VALUE_BITS   = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [39:0]  req_tdata,  // sample_index, feature_index, feature_value, class_label
   input  wire [2:0]   req_tuser,  // mode
   input  wire         req_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [55:0] rsp_tdata,  // predicted_class, correct, nearest_index,
                                   // correct_count, tested_count
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire [1:0]   csr_index,
   input  wire [15:0]  csr_data
);

   localparam int unsigned VB  = VALUE_BITS;
   localparam int unsigned TIW = MAX_TRAIN > 1 ? $clog2(MAX_TRAIN) : 1;
   localparam int unsigned TCW = $clog2(MAX_TRAIN + 2);
   localparam int unsigned FIW = MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1;
   localparam int unsigned FCW = $clog2(MAX_FEATURES + 1);
   localparam int unsigned TFD = MAX_TRAIN * MAX_FEATURES;
   localparam int unsigned TFW = $clog2(TFD);
   localparam int unsigned DW  = 3 * VB + FCW;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PRIME, ST_SCAN, ST_DRAIN, ST_PICK, ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic [15:0] thr_ff, thr_in;
   logic [6:0]  fcnt_ff, fcnt_in;
   logic [10:0] tcnt_ff, tcnt_in;
   logic loo_ff, loo_in, truth_ff, truth_in, qcls_ff, qcls_in, have_ff, have_in;
   logic [9:0] si_ff, si_in;
   logic [TFW-1:0] base_a_ff, base_a_in, base_b_ff, base_b_in;
   logic [TCW-1:0] s_ff, s_in;
   logic [FCW-1:0] k_ff, k_in;
   logic [TIW-1:0] best_ff, best_in;
   logic [DW-1:0] bestd_ff, bestd_in;
   logic [COUNT_BITS-1:0] hits_ff, hits_in, trials_ff, trials_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [55:0] rsp_data_ff, rsp_data_in;

   logic [9:0]  f_si;
   logic [5:0]  f_fi;
   logic [15:0] f_val;
   logic        f_cls;
   wnnc_mode_type f_mode;
   logic [31:0] si32, fi32, tc32, fc32, n32, nf32, kf32, s32, nx32, k32, v32, wa32;
   logic accept, fi_ok, si_ok, skipn, start, ok;
   logic [VB-1:0] val;

   logic we_w, we_q, we_t, we_c;
   logic [TFW-1:0] t_wr_addr, a_rd_addr, b_rd_addr;
   logic [TIW-1:0] c_addr, c_rd_addr;
   logic [VB-1:0] w_rd, q_rd, a_rd, b_rd;
   logic c_rd;

   wnnc_tag_type issue_tag, done_tag;
   logic [TIW-1:0] done_row;
   logic [DW-1:0] done_dist;
   logic busy;

   always_comb begin
      f_si   = req_tdata[9:0];
      f_fi   = req_tdata[15:10];
      f_val  = req_tdata[31:16];
      f_cls  = req_tdata[32];
      f_mode = wnnc_mode_type'(req_tuser);
      si32 = 32'(f_si);
      fi32 = 32'(f_fi);
      v32  = 32'(f_val);
      val  = v32[VB-1:0];
      fi_ok = fi32 < MAX_FEATURES;
      si_ok = si32 < MAX_TRAIN;
      wa32 = si32 * MAX_FEATURES + fi32;
      t_wr_addr = wa32[TFW-1:0];
      c_addr = si32[TIW-1:0];

      tc32 = 32'(tcnt_ff);
      n32  = tc32 < 2 ? 32'd2 : (tc32 > MAX_TRAIN ? MAX_TRAIN : tc32);
      fc32 = 32'(fcnt_ff);
      nf32 = fc32 > MAX_FEATURES ? MAX_FEATURES : fc32;
      kf32 = nf32 == 0 ? 32'd1 : nf32;
      s32  = 32'(s_ff);
      k32  = 32'(k_ff);
      skipn = loo_ff && (s32 + 1 == 32'(si_ff));
      nx32 = skipn ? s32 + 2 : s32 + 1;
      a_rd_addr = base_a_ff + k32[TFW-1:0];
      b_rd_addr = base_b_ff + k32[TFW-1:0];
      c_rd_addr = (state_ff == ST_IDLE) ? c_addr : best_ff;

      issue_tag.valid = state_ff == ST_SCAN;
      issue_tag.first = k_ff == '0;
      issue_tag.last  = k32 == kf32 - 1;
      issue_tag.used  = nf32 != 0;

      accept = req_tvalid && req_tready;
      we_w = 1'b0;
      we_q = 1'b0;
      we_t = 1'b0;
      we_c = 1'b0;
      start = 1'b0;
      ok = c_rd == truth_ff;

      state_in = state_ff;
      thr_in = thr_ff;
      fcnt_in = fcnt_ff;
      tcnt_in = tcnt_ff;
      loo_in = loo_ff;
      truth_in = truth_ff;
      qcls_in = qcls_ff;
      have_in = have_ff;
      si_in = si_ff;
      base_a_in = base_a_ff;
      base_b_in = base_b_ff;
      s_in = s_ff;
      k_in = k_ff;
      best_in = best_ff;
      bestd_in = bestd_ff;
      hits_in = hits_ff;
      trials_in = trials_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_THRESHOLD: thr_in  = csr_data;
            CSR_FEATURES:  fcnt_in = csr_data[6:0];
            CSR_SAMPLES:   tcnt_in = csr_data[10:0];
            default: ;
         endcase
      end

      if (accept) begin
         unique case (f_mode)
            MODE_WEIGHT: we_w = fi_ok;
            MODE_TRAIN: begin
               we_t = fi_ok && si_ok;
               we_c = fi_ok && si_ok;
            end
            MODE_QUERY: begin
               we_q = fi_ok;
               qcls_in = f_cls;
               start = req_tlast;
               loo_in = 1'b0;
            end
            MODE_LOO: begin
               start = si_ok;
               loo_in = 1'b1;
            end
            MODE_CLEAR: begin
               hits_in = '0;
               trials_in = '0;
            end
            default: ;
         endcase
      end

      if (start) begin
         si_in = f_si;
         base_b_in = wa32[TFW-1:0] - fi32[TFW-1:0];
         if (f_mode == MODE_LOO && f_si == '0) begin
            s_in = TCW'(1);
            base_a_in = TFW'(MAX_FEATURES);
         end else begin
            s_in = '0;
            base_a_in = '0;
         end
         k_in = '0;
         have_in = 1'b0;
         state_in = ST_PRIME;
      end

      if (done_tag.valid && done_tag.last && (!have_ff || done_dist < bestd_ff)) begin
         have_in = 1'b1;
         best_in = done_row;
         bestd_in = done_dist;
      end

      unique case (state_ff)
         ST_IDLE: ;
         ST_PRIME: begin
            truth_in = loo_ff ? c_rd : qcls_ff;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (k32 == kf32 - 1) begin
               k_in = '0;
               if (nx32 >= n32) begin
                  state_in = ST_DRAIN;
               end else begin
                  s_in = nx32[TCW-1:0];
                  base_a_in = base_a_ff + (skipn ? TFW'(2 * MAX_FEATURES)
                                                 : TFW'(MAX_FEATURES));
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!busy) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: state_in = ST_FINISH;
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               trials_in = trials_ff == COUNT_MAX ? trials_ff : trials_ff + 1'b1;
               hits_in = (ok && hits_ff != COUNT_MAX) ? hits_ff + 1'b1 : hits_ff;
               rsp_valid_in = 1'b1;
               rsp_data_in = {4'b0, trials_in, hits_in, 10'(32'(best_ff)), ok, c_rd};
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         thr_ff <= '0;
         fcnt_ff <= 7'd64;
         tcnt_ff <= 11'd2;
         qcls_ff <= 1'b0;
         have_ff <= 1'b0;
         hits_ff <= '0;
         trials_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         thr_ff <= thr_in;
         fcnt_ff <= fcnt_in;
         tcnt_ff <= tcnt_in;
         qcls_ff <= qcls_in;
         have_ff <= have_in;
         hits_ff <= hits_in;
         trials_ff <= trials_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      loo_ff <= loo_in;
      truth_ff <= truth_in;
      si_ff <= si_in;
      base_a_ff <= base_a_in;
      base_b_ff <= base_b_in;
      s_ff <= s_in;
      k_ff <= k_in;
      best_ff <= best_in;
      bestd_ff <= bestd_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = state_ff == ST_IDLE;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   wnnc_ram #(.WIDTH(VB), .DEPTH(MAX_FEATURES)) u_weight_ram (
      .clock(clock), .wr_en(we_w), .wr_addr(fi32[FIW-1:0]), .wr_data(val),
      .rd_addr(k_ff[FIW-1:0]), .rd_data(w_rd)
   );

   wnnc_ram #(.WIDTH(VB), .DEPTH(MAX_FEATURES)) u_query_ram (
      .clock(clock), .wr_en(we_q), .wr_addr(fi32[FIW-1:0]), .wr_data(val),
      .rd_addr(k_ff[FIW-1:0]), .rd_data(q_rd)
   );

   // two copies of the training features: scanned row and held-out row
   wnnc_ram #(.WIDTH(VB), .DEPTH(TFD)) u_train_ram (
      .clock(clock), .wr_en(we_t), .wr_addr(t_wr_addr), .wr_data(val),
      .rd_addr(a_rd_addr), .rd_data(a_rd)
   );

   wnnc_ram #(.WIDTH(VB), .DEPTH(TFD)) u_probe_ram (
      .clock(clock), .wr_en(we_t), .wr_addr(t_wr_addr), .wr_data(val),
      .rd_addr(b_rd_addr), .rd_data(b_rd)
   );

   wnnc_ram #(.WIDTH(1), .DEPTH(MAX_TRAIN)) u_class_ram (
      .clock(clock), .wr_en(we_c), .wr_addr(c_addr), .wr_data(f_cls),
      .rd_addr(c_rd_addr), .rd_data(c_rd)
   );

   wnnc_dist #(.VB(VB), .RW(TIW), .DW(DW)) u_dist (
      .clock(clock), .reset(reset),
      .issue_tag(issue_tag), .issue_row(s_ff[TIW-1:0]),
      .sel_train(loo_ff), .threshold(thr_ff),
      .query_data(q_rd), .probe_data(b_rd), .train_data(a_rd), .weight_data(w_rd),
      .done_tag(done_tag), .done_row(done_row), .done_dist(done_dist), .busy(busy)
   );

   a_hits_le_trials: assert property (@(posedge clock) disable iff (reset)
      hits_ff <= trials_ff) else $error("correct count exceeds tested count");

   a_have_at_finish: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PICK |-> have_ff) else $error("search ended without a candidate");

   a_no_issue_outside_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PICK |-> !busy) else $error("distance pipeline busy at pick");

endmodule
`default_nettype wire

// ===== rtl/wnnc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module wnnc_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 64
) (
   input  wire                                    clock,
   input  wire                                    wr_en,
   input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire [WIDTH-1:0]                        wr_data,
   input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ===== rtl/wnnc_dist.sv =====
// Pipelined weighted squared-distance accumulator, one feature per cycle.
// Depends on wnnc_pkg; fed by the memory reads issued in the top level.
`default_nettype none
module wnnc_dist
   import wnnc_pkg::*;
#(
   parameter int unsigned VB  = 16,
   parameter int unsigned RW  = 10,
   parameter int unsigned DW  = 55
) (
   input  wire               clock,
   input  wire               reset,
   input  wnnc_tag_type      issue_tag,
   input  wire [RW-1:0]      issue_row,
   input  wire               sel_train,
   input  wire [15:0]        threshold,
   input  wire [VB-1:0]      query_data,
   input  wire [VB-1:0]      probe_data,
   input  wire [VB-1:0]      train_data,
   input  wire [VB-1:0]      weight_data,
   output wnnc_tag_type      done_tag,
   output logic [RW-1:0]     done_row,
   output logic [DW-1:0]     done_dist,
   output logic              busy
);

   wnnc_tag_type tag0_ff, taga_ff, tagb_ff, tagc_ff, tagt_ff, tagd_ff;
   logic [RW-1:0] row0_ff, rowa_ff, rowb_ff, rowc_ff, rowt_ff, rowd_ff;
   logic [VB-1:0] da_ff, wa_ff, wb_ff;
   logic [VB-1:0] da_in, wa_in;
   logic [2*VB-1:0] d2_ff, pl_ff, ph_ff;
   logic [3*VB-1:0] term_ff;
   logic [DW-1:0] acc_ff, acc_in;
   logic [VB-1:0] opnd;
   logic [31:0] w32, t32;

   always_comb begin
      opnd  = sel_train ? probe_data : query_data;
      da_in = '0;
      if (tag0_ff.used) begin
         da_in = (opnd > train_data) ? opnd - train_data : train_data - opnd;
      end
      w32   = 32'(weight_data);
      t32   = 32'(threshold);
      wa_in = (tag0_ff.used && w32 >= t32) ? weight_data : '0;
      acc_in = (tagt_ff.first ? '0 : acc_ff) + DW'(term_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff <= '0;
         taga_ff <= '0;
         tagb_ff <= '0;
         tagc_ff <= '0;
         tagt_ff <= '0;
         tagd_ff <= '0;
      end else begin
         tag0_ff <= issue_tag;
         taga_ff <= tag0_ff;
         tagb_ff <= taga_ff;
         tagc_ff <= tagb_ff;
         tagt_ff <= tagc_ff;
         tagd_ff <= tagt_ff;
      end
      row0_ff <= issue_row;
      rowa_ff <= row0_ff;
      rowb_ff <= rowa_ff;
      rowc_ff <= rowb_ff;
      rowt_ff <= rowc_ff;
      rowd_ff <= rowt_ff;
      da_ff   <= da_in;
      wa_ff   <= wa_in;
      d2_ff   <= da_ff * da_ff;
      wb_ff   <= wa_ff;
      pl_ff   <= wb_ff * d2_ff[VB-1:0];
      ph_ff   <= wb_ff * d2_ff[2*VB-1:VB];
      term_ff <= (3*VB)'(pl_ff) + {ph_ff, {VB{1'b0}}};
      if (tagt_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign done_tag  = tagd_ff;
   assign done_row  = rowd_ff;
   assign done_dist = acc_ff;
   assign busy = tag0_ff.valid | taga_ff.valid | tagb_ff.valid | tagc_ff.valid
               | tagt_ff.valid | tagd_ff.valid;

endmodule
`default_nettype wire
